FILE: src/bb_pkg.sv
// ----------------------------------------------------------------------------
// bb_pkg
// Types, constants and sizes shared by the 3x3 RGB box blur block.
// ----------------------------------------------------------------------------
package bb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 16;
  localparam int RING_AW    = $clog2(2 * MAX_WIDTH + 3);
  localparam int RING_DEPTH = 2 ** RING_AW;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int SUM_W = 12;
  localparam int NUM_W = 13;
  localparam int DEN_W = 5;
  localparam int CNT_W = 4;

  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic               wr;
    logic [RING_AW-1:0] wr_addr;
    pix_t               px;
    logic               emit;
    logic [RING_AW-1:0] base;
    logic               has_up;
    logic               has_down;
    logic               has_left;
    logic               has_right;
    logic               last;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t ent;
  } qpush_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_ACC,
    B_START,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

FILE: src/bb_fifo.sv
// ----------------------------------------------------------------------------
// bb_fifo
// Short queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module bb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  bb_pkg::qpush_t q_push,
  input  logic           q_pop,
  output bb_pkg::qent_t  q_head,
  output bb_pkg::qstat_t q_stat
);
  import bb_pkg::*;

  qent_t           slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt;
  logic [Q_AW-1:0] rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (q_push.push) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (q_pop) begin
      rp_nxt = rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + (Q_AW + 1)'(q_push.push) - (Q_AW + 1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slot_r[wp_r] <= q_push.ent;
    end
  end

  assign q_head       = slot_r[rp_r];
  assign q_stat.full  = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

FILE: src/bb_front.sv
// ----------------------------------------------------------------------------
// bb_front
// Frame registers and raster counters; sorts each beat into store and/or
// emit work, or none, and queues it for the back when it has work.
// ----------------------------------------------------------------------------
module bb_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bb_pkg::in_beat_t                 in_data,
  input  logic                             cfg_we,
  input  logic [bb_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  bb_pkg::qstat_t                   q_stat,
  output bb_pkg::qpush_t                   q_push,
  output logic [bb_pkg::WW-1:0]            w_eff
);
  import bb_pkg::*;

  logic [FW_W-1:0]    fw_r, fw_nxt;
  logic [FH_W-1:0]    fh_r, fh_nxt;
  logic [COL_W-1:0]   in_col_r, in_col_nxt;
  logic [ROW_W-1:0]   in_row_r, in_row_nxt;
  logic [COL_W-1:0]   out_col_r, out_col_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [WW:0]        d_r, d_nxt;
  logic [RING_AW-1:0] in_ptr_r, in_ptr_nxt;
  logic [RING_AW-1:0] out_ptr_r, out_ptr_nxt;

  logic [WW-1:0]   w;
  logic [FH_W-1:0] h;
  logic            accept;
  logic            full;
  logic            wr;
  logic            emit;
  logic            last;
  logic            in_last_col;
  logic            out_last_col;
  logic            out_last_row;

  always_comb begin
    if (fw_r == '0) begin
      w = WW'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(fw_r);
    end
    h = (fh_r == '0) ? FH_W'(1) : fh_r;
  end

  assign accept       = in_valid && !q_stat.full;
  assign in_stall     = q_stat.full;
  assign full         = (in_row_r == h);
  assign wr           = !full && (in_data.cmd == CMD_PIXEL);
  assign emit         = full || (wr && (d_r > (WW + 1)'(w)));
  assign in_last_col  = (WW'(in_col_r) == w - WW'(1));
  assign out_last_col = (WW'(out_col_r) == w - WW'(1));
  assign out_last_row = (out_row_r == h - FH_W'(1));
  assign last         = emit && out_last_row && out_last_col;

  always_comb begin
    fw_nxt      = fw_r;
    fh_nxt      = fh_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    d_nxt       = d_r;
    in_ptr_nxt  = in_ptr_r;
    out_ptr_nxt = out_ptr_r;
    if (accept) begin
      if (wr) begin
        in_ptr_nxt = in_ptr_r + 1'b1;
        if (in_last_col) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + 1'b1;
        end else begin
          in_col_nxt = in_col_r + 1'b1;
        end
      end
      if (emit) begin
        out_ptr_nxt = out_ptr_r + 1'b1;
        if (out_last_col) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
      d_nxt = d_r + (WW + 1)'(wr) - (WW + 1)'(emit);
    end
    // frame restart on last result or on any register write
    if ((accept && last) || cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      d_nxt       = '0;
      in_ptr_nxt  = '0;
      out_ptr_nxt = '0;
    end
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  fw_nxt = cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_nxt = cfg_wdata[FH_W-1:0];
        default:          fw_nxt = fw_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= FRAME_WIDTH_RST;
      fh_r      <= FRAME_HEIGHT_RST;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      d_r       <= '0;
      in_ptr_r  <= '0;
      out_ptr_r <= '0;
    end else begin
      fw_r      <= fw_nxt;
      fh_r      <= fh_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      d_r       <= d_nxt;
      in_ptr_r  <= in_ptr_nxt;
      out_ptr_r <= out_ptr_nxt;
    end
  end

  always_comb begin
    q_push.push          = accept && (wr || emit);
    q_push.ent.wr        = wr;
    q_push.ent.wr_addr   = in_ptr_r;
    q_push.ent.px.red    = in_data.in_red;
    q_push.ent.px.green  = in_data.in_green;
    q_push.ent.px.blue   = in_data.in_blue;
    q_push.ent.emit      = emit;
    q_push.ent.base      = out_ptr_r;
    q_push.ent.has_up    = (out_row_r != '0);
    q_push.ent.has_down  = !out_last_row;
    q_push.ent.has_left  = (out_col_r != '0);
    q_push.ent.has_right = !out_last_col;
    q_push.ent.last      = last;
  end

  assign w_eff = w;

endmodule

FILE: src/bb_div.sv
// ----------------------------------------------------------------------------
// bb_div
// Restoring divider, one quotient bit per cycle, three channels sharing
// one divisor; the quotient is known to fit in eight bits.
// ----------------------------------------------------------------------------
module bb_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [2:0][bb_pkg::NUM_W-1:0]      num,
  input  logic [bb_pkg::DEN_W-1:0]           den,
  output logic                               done,
  output logic [2:0][7:0]                    quo
);
  import bb_pkg::*;

  logic [2:0][NUM_W-1:0] rem_r, rem_nxt;
  logic [2:0][7:0]       q_r, q_nxt;
  logic [DEN_W-1:0]      den_r, den_nxt;
  logic [2:0]            k_r, k_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [NUM_W-1:0]      sh;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = NUM_W'(den_r) << k_r;
    if (start) begin
      rem_nxt  = num;
      q_nxt    = '0;
      den_nxt  = den;
      k_nxt    = 3'd7;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int i = 0; i < 3; i++) begin
        if (rem_r[i] >= sh) begin
          rem_nxt[i]    = rem_r[i] - sh;
          q_nxt[i][k_r] = 1'b1;
        end
      end
      k_nxt = k_r - 1'b1;
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    k_r   <= k_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

FILE: src/bb_back.sv
// ----------------------------------------------------------------------------
// bb_back
// Line store, window gather over nine taps, rounding divide and the
// output register.
// ----------------------------------------------------------------------------
module bb_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [bb_pkg::WW-1:0]   w_eff,
  input  bb_pkg::qent_t           q_head,
  input  bb_pkg::qstat_t          q_stat,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output bb_pkg::out_beat_t       out_data
);
  import bb_pkg::*;

  localparam logic [1:0] TAP_LO  = 2'd0;
  localparam logic [1:0] TAP_MID = 2'd1;
  localparam logic [1:0] TAP_HI  = 2'd2;

  pix_t ring [RING_DEPTH];
  pix_t rd_data_r;

  back_state_t           st_r, st_nxt;
  qent_t                 ent_r, ent_nxt;
  logic [1:0]            tr_r, tr_nxt;
  logic [1:0]            tc_r, tc_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [2:0][SUM_W-1:0] sum_r, sum_nxt;
  logic                  acc_en_r;
  logic                  out_valid_r;
  out_beat_t             out_data_r;

  logic                  mem_we;
  logic                  rd_en;
  logic [RING_AW-1:0]    rd_addr;
  logic [RING_AW-1:0]    row_addr;
  logic [RING_AW-1:0]    wext;
  logic                  tap_ok;
  logic                  tap_last;
  logic                  div_start;
  logic                  div_done;
  logic                  load_out;
  logic                  slot_free;
  logic [2:0][7:0]       rd_ch;
  logic [2:0][NUM_W-1:0] num;
  logic [DEN_W-1:0]      den;
  logic [2:0][7:0]       quo;

  assign wext = RING_AW'(w_eff);

  always_comb begin
    case (tr_r)
      TAP_LO:  row_addr = ent_r.base - wext;
      TAP_HI:  row_addr = ent_r.base + wext;
      default: row_addr = ent_r.base;
    endcase
    case (tc_r)
      TAP_LO:  rd_addr = row_addr - 1'b1;
      TAP_HI:  rd_addr = row_addr + 1'b1;
      default: rd_addr = row_addr;
    endcase
  end

  assign tap_ok = (tr_r != TAP_LO || ent_r.has_up) && (tr_r != TAP_HI || ent_r.has_down) &&
                  (tc_r != TAP_LO || ent_r.has_left) && (tc_r != TAP_HI || ent_r.has_right);
  assign tap_last  = (tr_r == TAP_HI) && (tc_r == TAP_HI);
  assign slot_free = !out_valid_r || !out_stall;
  assign rd_ch     = {rd_data_r.red, rd_data_r.green, rd_data_r.blue};

  always_comb begin
    st_nxt    = st_r;
    ent_nxt   = ent_r;
    tr_nxt    = tr_r;
    tc_nxt    = tc_r;
    n_nxt     = n_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = sum_r[i] + (acc_en_r ? SUM_W'(rd_ch[i]) : SUM_W'(0));
    end
    unique case (st_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop  = 1'b1;
          mem_we = q_head.wr;
          if (q_head.emit) begin
            ent_nxt = q_head;
            tr_nxt  = TAP_LO;
            tc_nxt  = TAP_LO;
            n_nxt   = '0;
            sum_nxt = '0;
            st_nxt  = B_READ;
          end
        end
      end
      B_READ: begin
        rd_en = tap_ok;
        n_nxt = n_r + CNT_W'(tap_ok);
        if (tc_r == TAP_HI) begin
          tc_nxt = TAP_LO;
          tr_nxt = tr_r + 1'b1;
        end else begin
          tc_nxt = tc_r + 1'b1;
        end
        if (tap_last) begin
          st_nxt = B_ACC;
        end
      end
      B_ACC: begin
        st_nxt = B_START;
      end
      B_START: begin
        div_start = 1'b1;
        st_nxt    = B_DIV;
      end
      B_DIV: begin
        if (div_done) begin
          st_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (slot_free) begin
          load_out = 1'b1;
          st_nxt   = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[q_head.wr_addr] <= q_head.px;
    end
    if (rd_en) begin
      rd_data_r <= ring[rd_addr];
    end
  end

  // rounded mean: (2*sum + n) / (2*n)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'({sum_r[i], 1'b0}) + NUM_W'(n_r);
    end
    den = DEN_W'({n_r, 1'b0});
  end

  bb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      acc_en_r <= rd_en;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    tr_r  <= tr_nxt;
    tc_r  <= tc_nxt;
    n_r   <= n_nxt;
    sum_r <= sum_nxt;
    if (load_out) begin
      out_data_r.out_red   <= quo[2];
      out_data_r.out_green <= quo[1];
      out_data_r.out_blue  <= quo[0];
      out_data_r.frame_end <= ent_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/box_blur_3x3_rgb.sv
// Beats that only store a pixel or give nothing pass at one a cycle while the
// four-entry queue has room. A beat that completes a window also needs back
// work: the pop, nine tap positions walked one a cycle with in-frame taps read
// from the single-port line store, the accumulate and divide start, then an
// eight-step shared divider and the output load. Reset clears the raster
// counters and queue, sets width 640, height 480; the line store is not cleared.
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box blur of an RGB raster stream with in-frame neighbor averaging.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bb_pkg::in_beat_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bb_pkg::out_beat_t                out_data,
  input  logic                             cfg_we,
  input  logic [bb_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bb_pkg::*;

  qpush_t        q_push;
  qent_t         q_head;
  qstat_t        q_stat;
  logic          q_pop;
  logic [WW-1:0] w_eff;

  bb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .w_eff     (w_eff)
  );

  bb_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  bb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .w_eff     (w_eff),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push.push && q_stat.full))
    else $error("queue push while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_stat.empty))
    else $error("queue pop while empty");

  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full && !q_pop |=> q_stat.full)
    else $error("queue drained without a pop");

endmodule
